### sv/ncc_pkg.sv
// package for the newton cubic curve point generator
// holds the coefficient types, field widths and shared constants
// no dependencies
package ncc_pkg;

    // default number of parameter steps across one curve
    localparam int STEPS_DEFAULT = 10;

    // field widths
    localparam int COORD_W = 16;
    localparam int D1_W    = 17;
    localparam int DD2_W   = 18;
    localparam int F3_W    = 33;

    // parameter span 0..3 in q16, doubled for rounding of the step table
    localparam int SPAN2 = 2 * 3 * 65536;

    // per-axis coefficients handed from front to back
    typedef struct packed {
        logic signed [COORD_W-1:0] p0;
        logic signed [D1_W-1:0]    d1;
        logic signed [DD2_W-1:0]   dd2;
        logic signed [F3_W-1:0]    f3;
    } axis_coef_t;

    typedef struct packed {
        axis_coef_t x;
        axis_coef_t y;
    } coef_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### sv/ncc_front.sv
// front end: accepts control point transactions and forms divided differences
// depends on ncc_pkg; feeds ncc_queue
module ncc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [15:0]            first_x,
    input  logic signed [15:0]            first_y,
    input  logic signed [15:0]            second_x,
    input  logic signed [15:0]            second_y,
    input  logic signed [15:0]            third_x,
    input  logic signed [15:0]            third_y,
    input  logic signed [15:0]            fourth_x,
    input  logic signed [15:0]            fourth_y,
    output logic                          push,
    output ncc_pkg::coef_t                push_data,
    input  ncc_pkg::q_stat_t              stat
);

    // divide-by-three constants: bias keeps the third difference positive
    localparam logic [19:0] RECIP3   = 20'd699051;
    localparam logic [19:0] DD3_BIAS = 20'd786432;
    localparam logic [18:0] Q_BIAS   = 19'd262144;

    typedef struct packed {
        logic signed [15:0] p0;
        logic signed [16:0] d1;
        logic signed [17:0] dd2;
        logic [19:0]        u;
        logic [39:0]        prod;
    } pre_t;

    // differences and reciprocal product for one axis
    function automatic pre_t pre_axis(input logic signed [15:0] p0,
                                      input logic signed [15:0] p1,
                                      input logic signed [15:0] p2,
                                      input logic signed [15:0] p3);
        logic signed [18:0] t2;
        logic signed [20:0] t3;
        logic [20:0]        u_w;
        pre_t               r;
        r.p0  = p0;
        r.d1  = 17'(p1) - 17'(p0);
        t2    = 19'(p2) + 19'(p0) - (19'(p1) <<< 1);
        r.dd2 = t2[17:0];
        t3    = 21'(p3) - 21'(p2) * 21'sd3 + 21'(p1) * 21'sd3 - 21'(p0);
        u_w   = 21'(t3) + {1'b0, DD3_BIAS};
        r.u   = u_w[19:0];
        r.prod = 40'(r.u) * 40'(RECIP3);
        return r;
    endfunction

    // q16 fraction left over by the remainder of the divide by three
    function automatic logic [14:0] third_frac(input logic [1:0] r);
        logic [14:0] f;
        unique case (r)
            2'd1:    f = 15'd10923;
            2'd2:    f = 15'd21845;
            default: f = 15'd0;
        endcase
        return f;
    endfunction

    // finish the third divided difference from the registered product
    function automatic ncc_pkg::axis_coef_t post_axis(input pre_t s);
        logic [18:0]        q;
        logic [19:0]        rem_w;
        logic signed [18:0] k;
        ncc_pkg::axis_coef_t c;
        q      = s.prod[39:21];
        rem_w  = s.u - 20'(q) * 20'd3;
        k      = signed'(q - Q_BIAS);
        c.p0   = s.p0;
        c.d1   = s.d1;
        c.dd2  = s.dd2;
        c.f3   = (33'(k) <<< 15) + 33'(third_frac(rem_w[1:0]));
        return c;
    endfunction

    logic s1_valid_reg;
    logic s1_valid_next;
    pre_t s1_x_reg;
    pre_t s1_y_reg;

    // hold the transaction while the queue is full
    assign in_stall = s1_valid_reg && stat.full;
    assign push     = s1_valid_reg && !stat.full;

    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload stage: differences and multiply
    always_ff @(posedge clk) begin
        if (!in_stall && in_valid) begin
            s1_x_reg <= pre_axis(first_x, second_x, third_x, fourth_x);
            s1_y_reg <= pre_axis(first_y, second_y, third_y, fourth_y);
        end
    end

    assign push_data.x = post_axis(s1_x_reg);
    assign push_data.y = post_axis(s1_y_reg);

endmodule

### sv/ncc_queue.sv
// two-entry coefficient queue between front end and evaluator
// depends on ncc_pkg
module ncc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ncc_pkg::coef_t    push_data,
    input  logic              pop,
    output ncc_pkg::coef_t    pop_data,
    output ncc_pkg::q_stat_t  stat
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    ncc_pkg::coef_t   entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_next;

    assign stat.full  = (cnt_reg == CNT_W'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue read while empty");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(Q_DEPTH))
        else $error("queue fill count out of range");

endmodule

### sv/ncc_back.sv
// back end: steps the parameter and evaluates the newton cubic per point
// depends on ncc_pkg; reads from ncc_queue
module ncc_back #(
    parameter int STEPS = ncc_pkg::STEPS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    output logic              pop,
    input  ncc_pkg::coef_t    pop_data,
    input  ncc_pkg::q_stat_t  stat,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       pixel_x,
    output logic [15:0]       pixel_y,
    output logic              last_point
);

    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(STEPS);

    // parameter table: s = round(3*i/STEPS) in q16
    logic [17:0] s_tab [STEPS+1];
    for (genvar gi = 0; gi <= STEPS; gi++) begin : g_s_tab
        assign s_tab[gi] = 18'((gi * ncc_pkg::SPAN2 + STEPS) / (2 * STEPS));
    end

    // saturate the rounded q32 sum to an unsigned pixel
    function automatic logic [15:0] sat_pixel(input logic signed [55:0] t);
        logic [15:0] p;
        if (t[55]) begin
            p = 16'd0;
        end
        else if (|t[54:48]) begin
            p = 16'hffff;
        end
        else begin
            p = t[47:32];
        end
        return p;
    endfunction

    logic adv;

    // issue stage
    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    ncc_pkg::coef_t   coef_reg;

    // stage 1
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [17:0]        s1_a_reg;
    logic signed [18:0] s1_c_reg;
    logic signed [37:0] s1_abr_reg;
    ncc_pkg::coef_t     s1_coef_reg;

    // stage 2
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic signed [38:0] s2_abcr_reg;
    logic signed [35:0] s2_pa_x_reg;
    logic signed [35:0] s2_pa_y_reg;
    logic signed [37:0] s2_pb_x_reg;
    logic signed [37:0] s2_pb_y_reg;
    logic signed [15:0] s2_p0_x_reg;
    logic signed [15:0] s2_p0_y_reg;
    logic signed [32:0] s2_f3_x_reg;
    logic signed [32:0] s2_f3_y_reg;

    // stage 3
    logic               s3_valid_reg;
    logic               s3_last_reg;
    logic signed [55:0] s3_part_x_reg;
    logic signed [55:0] s3_part_y_reg;
    logic signed [52:0] s3_pc_x_reg;
    logic signed [52:0] s3_pc_y_reg;

    // output stage
    logic        out_valid_reg;
    logic [15:0] pixel_x_reg;
    logic [15:0] pixel_y_reg;
    logic        last_reg;

    // whole pipe moves when the output register is free or being taken
    assign adv = !out_valid_reg || !out_stall;

    // take the next curve once the current one issues its last point
    assign pop = adv && !stat.empty && (!busy_reg || cnt_reg == LAST_IDX);

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (adv) begin
            priority if (pop) begin
                busy_next = 1'b1;
                cnt_next  = '0;
            end
            else if (busy_reg && cnt_reg == LAST_IDX) begin
                busy_next = 1'b0;
            end
            else if (busy_reg) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // stage 1 datapath: a, c and a*b
    logic [17:0]        a_w;
    logic signed [18:0] b_w;
    logic signed [18:0] c_w;
    assign a_w = s_tab[cnt_reg];
    assign b_w = signed'({1'b0, a_w}) - 19'sd65536;
    assign c_w = signed'({1'b0, a_w}) - 19'sd131072;

    // stage 2 datapath: round ab, then ab*c, d1*a, dd2*ab
    logic signed [37:0] ab_round_w;
    logic signed [19:0] ab_w;
    logic signed [18:0] a_s_w;
    assign ab_round_w = s1_abr_reg + 38'sd32768;
    assign ab_w       = ab_round_w[35:16];
    assign a_s_w      = signed'({1'b0, s1_a_reg});

    // stage 3 datapath: round abc, then f3*abc and the partial sum
    logic signed [38:0] abc_round_w;
    logic signed [19:0] abc_w;
    assign abc_round_w = s2_abcr_reg + 39'sd32768;
    assign abc_w       = abc_round_w[35:16];

    // control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (adv) begin
                s1_valid_reg  <= busy_reg;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        if (pop) begin
            coef_reg <= pop_data;
        end
        if (adv) begin
            s1_last_reg <= (cnt_reg == LAST_IDX);
            s1_a_reg    <= a_w;
            s1_c_reg    <= c_w;
            s1_abr_reg  <= 38'(signed'({1'b0, a_w})) * 38'(b_w);
            s1_coef_reg <= coef_reg;

            s2_last_reg <= s1_last_reg;
            s2_abcr_reg <= 39'(ab_w) * 39'(s1_c_reg);
            s2_pa_x_reg <= 36'(s1_coef_reg.x.d1) * 36'(a_s_w);
            s2_pa_y_reg <= 36'(s1_coef_reg.y.d1) * 36'(a_s_w);
            s2_pb_x_reg <= 38'(s1_coef_reg.x.dd2) * 38'(ab_w);
            s2_pb_y_reg <= 38'(s1_coef_reg.y.dd2) * 38'(ab_w);
            s2_p0_x_reg <= s1_coef_reg.x.p0;
            s2_p0_y_reg <= s1_coef_reg.y.p0;
            s2_f3_x_reg <= s1_coef_reg.x.f3;
            s2_f3_y_reg <= s1_coef_reg.y.f3;

            s3_last_reg   <= s2_last_reg;
            s3_pc_x_reg   <= 53'(s2_f3_x_reg) * 53'(abc_w);
            s3_pc_y_reg   <= 53'(s2_f3_y_reg) * 53'(abc_w);
            s3_part_x_reg <= (56'(s2_p0_x_reg) <<< 32) + (56'(s2_pa_x_reg) <<< 16)
                           + (56'(s2_pb_x_reg) <<< 15) + 56'sd2147483648;
            s3_part_y_reg <= (56'(s2_p0_y_reg) <<< 32) + (56'(s2_pa_y_reg) <<< 16)
                           + (56'(s2_pb_y_reg) <<< 15) + 56'sd2147483648;

            last_reg    <= s3_last_reg;
            pixel_x_reg <= sat_pixel(s3_part_x_reg + 56'(s3_pc_x_reg));
            pixel_y_reg <= sat_pixel(s3_part_y_reg + 56'(s3_pc_y_reg));
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_point = last_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= LAST_IDX)
        else $error("step counter beyond last step");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> $stable(s1_valid_reg)
            && $stable(s2_valid_reg) && $stable(s3_valid_reg) && $stable(cnt_reg))
        else $error("pipeline moved while output stalled");

    a_pop_rule: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty && (!busy_reg || cnt_reg == LAST_IDX))
        else $error("new curve taken before current one finished");

endmodule

### sv/newton_cubic_curve_points.sv
// Newton cubic curve point generator, top level.
// Input channel (in_valid/in_stall): one transaction carries four signed
// control points placed at parameters 0, 1, 2 and 3.
// Output channel (out_valid/out_stall): STEPS+1 transactions per input, one
// pixel pair each at s = 3*i/STEPS, rounded half up and clamped to 0..65535;
// last_point marks the final pair of a curve.
// Each input passes the front register, the queue, the coefficient register and
// evaluator stages 1 to 3 before its points reach the output register.
// Throughput: a single-point-per-cycle evaluator feeds the output register while
// out_stall lets the pipe move; a two-entry coefficient queue lets
// the front take new inputs while the evaluator is still busy.
// Output stall freezes the whole evaluator pipeline; the queue then fills and
// the input side stalls. Reset (rst_n, asynchronous) empties the queue and
// pipeline; no results are pending afterwards.
// depends on ncc_pkg, ncc_front, ncc_queue, ncc_back
module newton_cubic_curve_points #(
    parameter int STEPS = ncc_pkg::STEPS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] first_x,
    input  logic signed [15:0] first_y,
    input  logic signed [15:0] second_x,
    input  logic signed [15:0] second_y,
    input  logic signed [15:0] third_x,
    input  logic signed [15:0] third_y,
    input  logic signed [15:0] fourth_x,
    input  logic signed [15:0] fourth_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        pixel_x,
    output logic [15:0]        pixel_y,
    output logic               last_point
);

    logic              push;
    logic              pop;
    ncc_pkg::coef_t    push_data;
    ncc_pkg::coef_t    pop_data;
    ncc_pkg::q_stat_t  stat;

    // accept and form divided differences
    ncc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .third_x   (third_x),
        .third_y   (third_y),
        .fourth_x  (fourth_x),
        .fourth_y  (fourth_y),
        .push      (push),
        .push_data (push_data),
        .stat      (stat)
    );

    // decoupling queue
    ncc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    // point evaluator
    ncc_back #(
        .STEPS (STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_data   (pop_data),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_point (last_point)
    );

endmodule

### tb/newton_cubic_curve_points_tb.sv
// testbench for the newton cubic curve point generator
// predicts every pixel pair of each curve and checks the output channel in order
// depends on ncc_pkg and newton_cubic_curve_points
module newton_cubic_curve_points_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTEPS      = ncc_pkg::STEPS_DEFAULT;
    localparam int RST_CYCLES  = 11;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_SETS = 150;

    // four control points of one curve
    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic signed [15:0] x2;
        logic signed [15:0] y2;
        logic signed [15:0] x3;
        logic signed [15:0] y3;
    } ctrl_pts_t;

    // one predicted pixel pair
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } pixel_t;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic signed [15:0] first_x    = '0;
    logic signed [15:0] first_y    = '0;
    logic signed [15:0] second_x   = '0;
    logic signed [15:0] second_y   = '0;
    logic signed [15:0] third_x    = '0;
    logic signed [15:0] third_y    = '0;
    logic signed [15:0] fourth_x   = '0;
    logic signed [15:0] fourth_y   = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [15:0]        pixel_x;
    logic [15:0]        pixel_y;
    logic               last_point;

    ctrl_pts_t curve_inputs [$];
    pixel_t    expected_pixels [$];
    ctrl_pts_t held_pts = '0;
    ctrl_pts_t next_pts;
    pixel_t    want_px;

    int sender_idle_pct   = 30;
    int receiver_idle_pct = 55;
    int error_count       = 0;
    int cycle_count       = 0;

    newton_cubic_curve_points #(
        .STEPS(NSTEPS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .third_x   (third_x),
        .third_y   (third_y),
        .fourth_x  (fourth_x),
        .fourth_y  (fourth_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last_point(last_point)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // division rounding towards minus infinity
    function automatic longint floor_div(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    // drop n fractional bits, rounding half up
    function automatic longint round_half_up(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        return (v + half) >>> n;
    endfunction

    // one axis of the cubic through points at 0..3, evaluated at q16 parameter s
    function automatic logic [15:0] cubic_axis_value(longint p0, longint p1, longint p2,
                                                     longint p3, longint s);
        longint d1, f2, f3, ab, abc, total, v;
        d1    = p1 - p0;
        f2    = (p2 - 2 * p1 + p0) * 32768;
        f3    = floor_div((p3 - 3 * p2 + 3 * p1 - p0) * 65536 + 3, 6);
        ab    = round_half_up(s * (s - 65536), 16);
        abc   = round_half_up(ab * (s - 131072), 16);
        total = d1 * s * 65536 + f2 * ab + f3 * abc;
        v     = round_half_up(p0 * (longint'(1) << 32) + total, 32);
        if (v < 0)
            v = 0;
        else if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // all pixel pairs that one accepted curve produces
    task automatic predict_curve(ctrl_pts_t c);
        pixel_t px;
        longint s;
        for (int i = 0; i <= NSTEPS; i++)
        begin
            s       = (longint'(i) * 3 * 65536 * 2 + NSTEPS) / (2 * NSTEPS);
            px.x    = cubic_axis_value(c.x0, c.x1, c.x2, c.x3, s);
            px.y    = cubic_axis_value(c.y0, c.y1, c.y2, c.y3, s);
            px.last = (i == NSTEPS);
            expected_pixels.push_back(px);
        end
    endtask

    task automatic add_curve(int ax0, int ay0, int ax1, int ay1,
                             int ax2, int ay2, int ax3, int ay3);
        ctrl_pts_t c;
        c.x0 = ax0[15:0];
        c.y0 = ay0[15:0];
        c.x1 = ax1[15:0];
        c.y1 = ay1[15:0];
        c.x2 = ax2[15:0];
        c.y2 = ay2[15:0];
        c.x3 = ax3[15:0];
        c.y3 = ay3[15:0];
        curve_inputs.push_back(c);
    endtask

    // coordinate flavours: full range, screen-like, near the extremes
    function automatic int pick_coord(int flavour);
        int corner [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        case (flavour)
            0:       return $urandom_range(65535);
            1:       return $urandom_range(1100) - 50;
            default: return corner[$urandom_range(6)];
        endcase
    endfunction

    task automatic add_random_curves(int count);
        int flavour;
        for (int n = 0; n < count; n++)
        begin
            flavour = $urandom_range(2);
            add_curve(pick_coord(flavour), pick_coord(flavour), pick_coord(flavour),
                      pick_coord(flavour), pick_coord(flavour), pick_coord(flavour),
                      pick_coord(flavour), pick_coord(flavour));
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // driver: presents queued curves, holding each while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_curve(held_pts);
            if (!in_valid || !in_stall)
            begin
                if (curve_inputs.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_pts = curve_inputs.pop_front();
                    held_pts <= next_pts;
                    first_x  <= next_pts.x0;
                    first_y  <= next_pts.y0;
                    second_x <= next_pts.x1;
                    second_y <= next_pts.y1;
                    third_x  <= next_pts.x2;
                    third_y  <= next_pts.y2;
                    fourth_x <= next_pts.x3;
                    fourth_y <= next_pts.y3;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each output transaction and drives a random stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected point, expected none, actual x %0d y %0d last %0b",
                             $time, pixel_x, pixel_y, last_point);
                end
                else
                begin
                    want_px = expected_pixels.pop_front();
                    check_field("pixel_x", want_px.x, pixel_x);
                    check_field("pixel_y", want_px.y, pixel_y);
                    check_field("last_point", {15'd0, want_px.last}, {15'd0, last_point});
                end
            end
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("newton_cubic_curve_points_tb NOT OK");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed curves: flat, extremes, straight lines, overshoot and clamping
        add_curve(0, 0, 0, 0, 0, 0, 0, 0);
        add_curve(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_curve(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_curve(-1, -1, -1, -1, -1, -1, -1, -1);
        add_curve(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768);
        add_curve(32767, -32768, -32768, 32767, -32768, 32767, 32767, -32768);
        add_curve(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
        add_curve(0, 300, 100, 200, 200, 100, 300, 0);
        add_curve(0, 5, 1, -5, 4, 5, 9, -5);
        add_curve(0, 1, 1, 0, 8, 0, 27, 1);
        add_curve(0, 1, 1, 0, 0, 1, 0, 0);
        add_curve(0, 32767, 0, 0, 0, 0, 32767, 0);
        add_curve(1000, 600, 2000, -20, 1500, 700, 500, 900);
        add_curve(21845, -21846, -21846, 21845, 21845, -21846, -21846, 21845);
        add_curve(-5, -300, -10, -200, -20, -100, -40, -1);
        add_curve(65535 - 32767, 1, 32766, 2, 32767, 3, 32767, 32767);

        // sender idles 30 %, receiver 55 %
        add_random_curves(RANDOM_SETS / 3);
        while (curve_inputs.size() != 0)
            @(negedge clk);

        // the other way round
        sender_idle_pct   = 55;
        receiver_idle_pct = 30;
        add_random_curves(RANDOM_SETS / 3);
        while (curve_inputs.size() != 0)
            @(negedge clk);

        // full speed
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        add_random_curves(RANDOM_SETS - 2 * (RANDOM_SETS / 3));

        // drain
        while (curve_inputs.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (NSTEPS + 16) @(negedge clk);

        if (error_count == 0)
            $display("newton_cubic_curve_points_tb OK");
        else
            $display("newton_cubic_curve_points_tb NOT OK");
        $finish;
    end

endmodule
